@@ src/readout_block_hit_unpacker_assert.svh @@
// ----------------------------------------------------------------------------
// readout block hit unpacker assertion macros
// shared property wrappers clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef READOUT_BLOCK_HIT_UNPACKER_ASSERT_SVH
`define READOUT_BLOCK_HIT_UNPACKER_ASSERT_SVH

// same-cycle implication
`define RBHU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rbhu assertion failed");

// next-cycle implication
`define RBHU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rbhu assertion failed");

`endif

@@ src/rbhu_pkg.sv @@
// ----------------------------------------------------------------------------
// rbhu_pkg
// types and constants shared by the readout block hit unpacker modules
// ----------------------------------------------------------------------------
package rbhu_pkg;

   localparam int HIT_INDEX_BITS = 16;
   localparam int WORD_BITS      = 32;
   localparam int COUNT_BITS     = 9;
   localparam int OUT_INDEX_BITS = 16;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_FIRST  = 2'd1,
      PH_SECOND = 2'd2
   } phase_type;

   typedef struct packed {
      logic [3:0]                module_id;
      logic [3:0]                cable_id;
      logic [4:0]                tac_address;
      logic [4:0]                tac_channel;
      logic [3:0]                calibration;
      logic [5:0]                clock_count;
      logic [11:0]               tac_value;
      logic [11:0]               qdc_value;
      logic [OUT_INDEX_BITS-1:0] hit_index;
   } hit_type;

endpackage

@@ src/rbhu_parser.sv @@
// ----------------------------------------------------------------------------
// rbhu_parser
// header / hit-pair parser: tracks block phase and builds one hit per pair
// ----------------------------------------------------------------------------
module rbhu_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [rbhu_pkg::WORD_BITS-1:0]      word,
   input  logic                                start_of_buffer,
   output logic                                hit_valid,
   output rbhu_pkg::hit_type                   hit
);
   import rbhu_pkg::*;

   phase_type                   phase_ff, phase_in;
   logic [COUNT_BITS-1:0]       pairs_left_ff, pairs_left_in;
   logic [3:0]                  module_ff, module_in;
   logic [3:0]                  cable_ff, cable_in;
   logic [WORD_BITS-1:0]        first_ff, first_in;
   logic [HIT_INDEX_BITS-1:0]   hit_count_ff, hit_count_in;
   logic [COUNT_BITS:0]         count_plus;
   logic [COUNT_BITS-1:0]       header_pairs;
   logic [COUNT_BITS-1:0]       pairs_dec;
   logic [31:0]                 count_wide;

   // rounds the word count up to whole pairs
   assign count_plus   = {1'b0, word[COUNT_BITS-1:0]} + {{COUNT_BITS{1'b0}}, 1'b1};
   assign header_pairs = count_plus[COUNT_BITS:1];
   assign pairs_dec    = pairs_left_ff - {{(COUNT_BITS-1){1'b0}}, 1'b1};
   assign count_wide   = 32'(hit_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         pairs_left_ff <= '0;
         module_ff     <= '0;
         cable_ff      <= '0;
         first_ff      <= '0;
         hit_count_ff  <= '0;
      end else begin
         phase_ff      <= phase_in;
         pairs_left_ff <= pairs_left_in;
         module_ff     <= module_in;
         cable_ff      <= cable_in;
         first_ff      <= first_in;
         hit_count_ff  <= hit_count_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      pairs_left_in = pairs_left_ff;
      module_in     = module_ff;
      cable_in      = cable_ff;
      first_in      = first_ff;
      hit_count_in  = hit_count_ff;
      hit_valid     = 1'b0;

      hit.module_id   = module_ff;
      hit.cable_id    = cable_ff;
      hit.tac_address = first_ff[31:27];
      hit.tac_channel = first_ff[26:22];
      hit.calibration = first_ff[21:18];
      hit.clock_count = ~first_ff[17:12];
      hit.tac_value   = ~first_ff[11:0];
      hit.qdc_value   = word[11:0];
      hit.hit_index   = count_wide[OUT_INDEX_BITS-1:0];

      if (accept) begin
         if (start_of_buffer || (phase_ff != PH_FIRST && phase_ff != PH_SECOND)) begin
            if (start_of_buffer) begin
               hit_count_in = '0;
            end
            module_in     = word[31:28];
            cable_in      = word[27:24];
            pairs_left_in = header_pairs;
            phase_in      = (header_pairs == '0) ? PH_HEADER : PH_FIRST;
         end else if (phase_ff == PH_FIRST) begin
            first_in = word;
            phase_in = PH_SECOND;
         end else begin
            hit_valid     = 1'b1;
            // index saturates at all ones
            if (hit_count_ff != '1) begin
               hit_count_in = hit_count_ff + {{(HIT_INDEX_BITS-1){1'b0}}, 1'b1};
            end
            pairs_left_in = pairs_dec;
            phase_in      = (pairs_dec == '0) ? PH_HEADER : PH_FIRST;
         end
      end
   end

endmodule

@@ src/readout_block_hit_unpacker.sv @@
// a hit is registered into the output register (or the skid entry if rsp is held)
// from the beat carrying its second word; one word per cycle while req_stall is low
// a two-entry result buffer (output register plus skid) lets req beats keep flowing
// while a finished hit waits; req_stall rises only when both entries are full
// reset clears parse phase, pair count, ids, hit index, valid bits of both buffers
// ----------------------------------------------------------------------------
// readout_block_hit_unpacker
// unpacks readout block headers and hit word pairs into hit records
// ----------------------------------------------------------------------------
module readout_block_hit_unpacker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rbhu_pkg::WORD_BITS-1:0]       req_word,
   input  logic                                 req_start_of_buffer,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [3:0]                           rsp_module_id,
   output logic [3:0]                           rsp_cable_id,
   output logic [4:0]                           rsp_tac_address,
   output logic [4:0]                           rsp_tac_channel,
   output logic [3:0]                           rsp_calibration,
   output logic [5:0]                           rsp_clock_count,
   output logic [11:0]                          rsp_tac_value,
   output logic [11:0]                          rsp_qdc_value,
   output logic [rbhu_pkg::OUT_INDEX_BITS-1:0]  rsp_hit_index
);
   import rbhu_pkg::*;

   logic    accept;
   logic    hit_valid;
   hit_type hit;
   logic    take_out;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   hit_type out_ff, out_in;
   hit_type skid_ff, skid_in;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;
   assign take_out  = out_valid_ff & ~rsp_stall;

   rbhu_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .word            (req_word),
      .start_of_buffer (req_start_of_buffer),
      .hit_valid       (hit_valid),
      .hit             (hit)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // no beat taken while the skid entry is full
         if (take_out) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (hit_valid) begin
         if (!out_valid_ff || take_out) begin
            out_in       = hit;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = hit;
            skid_valid_in = 1'b1;
         end
      end else if (take_out) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_module_id   = out_ff.module_id;
   assign rsp_cable_id    = out_ff.cable_id;
   assign rsp_tac_address = out_ff.tac_address;
   assign rsp_tac_channel = out_ff.tac_channel;
   assign rsp_calibration = out_ff.calibration;
   assign rsp_clock_count = out_ff.clock_count;
   assign rsp_tac_value   = out_ff.tac_value;
   assign rsp_qdc_value   = out_ff.qdc_value;
   assign rsp_hit_index   = out_ff.hit_index;

endmodule

@@ src/rbhu_checker.sv @@
// ----------------------------------------------------------------------------
// rbhu_checker
// port-level checks for the readout block hit unpacker, bound to the top level
// ----------------------------------------------------------------------------
`include "readout_block_hit_unpacker_assert.svh"

module rbhu_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 req_start_of_buffer,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [3:0]                           rsp_module_id,
   input  logic [3:0]                           rsp_cable_id,
   input  logic [4:0]                           rsp_tac_address,
   input  logic [4:0]                           rsp_tac_channel,
   input  logic [3:0]                           rsp_calibration,
   input  logic [5:0]                           rsp_clock_count,
   input  logic [11:0]                          rsp_tac_value,
   input  logic [11:0]                          rsp_qdc_value,
   input  logic [rbhu_pkg::OUT_INDEX_BITS-1:0]  rsp_hit_index
);
   import rbhu_pkg::*;

   logic    start_beat;
   hit_type rsp_payload;

   assign start_beat  = req_valid && !req_stall && req_start_of_buffer;
   assign rsp_payload = {rsp_module_id, rsp_cable_id, rsp_tac_address, rsp_tac_channel,
                         rsp_calibration, rsp_clock_count, rsp_tac_value, rsp_qdc_value,
                         rsp_hit_index};

   // a held beat stays put
   `RBHU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `RBHU_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_payload))
   // input backs up only once the result buffer holds a waiting hit
   `RBHU_ASSERT_NOW(a_stall_needs_rsp, req_stall, rsp_valid)
   // a start-of-buffer header beat into an idle output never produces a hit
   `RBHU_ASSERT_NEXT(a_start_no_hit, start_beat && !rsp_valid, !rsp_valid)

endmodule

bind readout_block_hit_unpacker rbhu_checker u_rbhu_checker (.*);
